FILE: src/uifb_pkg.sv
// shared types, constants and codes of the udp/ipv4 frame builder
package uifb_pkg;

    localparam int HDR_LEN         = 42;
    localparam int MAX_PAYLOAD_DEF = 1400;
    localparam int MIN_FRAME_DEF   = 60;
    localparam int LEN_W           = 11;
    localparam int IDX_W           = 6;
    localparam int CSUM_WORDS      = 8;
    localparam int IP_UDP_HDR      = 28;
    localparam int UDP_HDR         = 8;

    localparam logic [31:0] SRC_IP_RESET   = 32'h0A00_020F;
    localparam logic [7:0]  BCAST_BYTE     = 8'hFF;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  IP_VER_IHL     = 8'h45;
    localparam logic [7:0]  IP_TTL         = 8'd64;
    localparam logic [7:0]  IP_PROTO_UDP   = 8'd17;

    typedef enum logic [1:0] {
        CFG_SOURCE_MAC = 2'd0,
        CFG_SOURCE_IP  = 2'd1,
        CFG_LINK_READY = 2'd2
    } t_cfg_idx;

    localparam logic FUNC_START_C   = 1'b0;
    localparam logic FUNC_PAYLOAD_C = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CSUM,
        S_HDR,
        S_PAY,
        S_PAD,
        S_REJ
    } t_state;

    // words fed to the checksum unit
    typedef struct packed {
        logic [15:0] ip_len;
        logic [15:0] ident;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
    } t_csum_in;

    typedef struct packed {
        logic        done;
        logic [15:0] csum;
    } t_csum_out;

    typedef struct packed {
        logic [47:0] src_mac;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [15:0] ip_len;
        logic [15:0] ident;
        logic [15:0] udp_len;
        logic [15:0] csum;
    } t_hdr_fields;

endpackage

FILE: src/uifb_if.sv
// handshake channels of the frame builder: input items, frame bytes, register writes
interface uifb_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [31:0] dest_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [15:0] payload_length;
    logic [15:0] ip_ident;
    logic [7:0]  data_byte;

    modport source (output valid, func, dest_ip, sport, dport, payload_length,
                    ip_ident, data_byte, input ready);
    modport sink   (input valid, func, dest_ip, sport, dport, payload_length,
                    ip_ident, data_byte, output ready);
endinterface

interface uifb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last;
    logic       status;

    modport source (output valid, frame_byte, last, status, input ready);
    modport sink   (input valid, frame_byte, last, status, output ready);
endinterface

interface uifb_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [47:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/uifb_csum.sv
// ipv4 header checksum: one 16-bit end-around-carry adder stepped over the header words
module uifb_csum
    import uifb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_csum_in  i_words,
    output t_csum_out o_res
);

    localparam int CNT_W = $clog2(CSUM_WORDS + 1);

    logic             r_busy, n_busy;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [16:0]      r_acc, n_acc;
    logic [15:0]      w_word;
    logic             w_done;

    always_comb begin
        case (r_idx)
            CNT_W'(0): w_word = {IP_VER_IHL, 8'h00};
            CNT_W'(1): w_word = i_words.ip_len;
            CNT_W'(2): w_word = i_words.ident;
            CNT_W'(3): w_word = {IP_TTL, IP_PROTO_UDP};
            CNT_W'(4): w_word = i_words.src_ip[31:16];
            CNT_W'(5): w_word = i_words.src_ip[15:0];
            CNT_W'(6): w_word = i_words.dst_ip[31:16];
            CNT_W'(7): w_word = i_words.dst_ip[15:0];
            default:   w_word = 16'h0000;
        endcase
    end

    // after the last word, keep folding the carry back in until none is left
    assign w_done = r_busy && (r_idx == CNT_W'(CSUM_WORDS)) && !r_acc[16];

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        n_acc  = r_acc;
        if (i_start) begin
            n_busy = 1'b1;
            n_idx  = '0;
            n_acc  = '0;
        end else if (w_done) begin
            n_busy = 1'b0;
        end else if (r_busy) begin
            n_acc = {1'b0, r_acc[15:0]} + 17'(r_acc[16]) + {1'b0, w_word};
            if (r_idx != CNT_W'(CSUM_WORDS)) begin
                n_idx = r_idx + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
        r_acc <= n_acc;
    end

    assign o_res.done = w_done;
    assign o_res.csum = ~r_acc[15:0];

endmodule

FILE: src/uifb_hdr.sv
// picks one of the 42 ethernet/ipv4/udp header bytes by position
module uifb_hdr
    import uifb_pkg::*;
(
    input  t_hdr_fields      i_fields,
    input  logic [IDX_W-1:0] i_idx,
    output logic [7:0]       o_byte
);

    always_comb begin
        case (i_idx)
            6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5: o_byte = BCAST_BYTE;
            6'd6:  o_byte = i_fields.src_mac[47:40];
            6'd7:  o_byte = i_fields.src_mac[39:32];
            6'd8:  o_byte = i_fields.src_mac[31:24];
            6'd9:  o_byte = i_fields.src_mac[23:16];
            6'd10: o_byte = i_fields.src_mac[15:8];
            6'd11: o_byte = i_fields.src_mac[7:0];
            6'd12: o_byte = ETHERTYPE_IPV4[15:8];
            6'd13: o_byte = ETHERTYPE_IPV4[7:0];
            6'd14: o_byte = IP_VER_IHL;
            6'd16: o_byte = i_fields.ip_len[15:8];
            6'd17: o_byte = i_fields.ip_len[7:0];
            6'd18: o_byte = i_fields.ident[15:8];
            6'd19: o_byte = i_fields.ident[7:0];
            6'd22: o_byte = IP_TTL;
            6'd23: o_byte = IP_PROTO_UDP;
            6'd24: o_byte = i_fields.csum[15:8];
            6'd25: o_byte = i_fields.csum[7:0];
            6'd26: o_byte = i_fields.src_ip[31:24];
            6'd27: o_byte = i_fields.src_ip[23:16];
            6'd28: o_byte = i_fields.src_ip[15:8];
            6'd29: o_byte = i_fields.src_ip[7:0];
            6'd30: o_byte = i_fields.dst_ip[31:24];
            6'd31: o_byte = i_fields.dst_ip[23:16];
            6'd32: o_byte = i_fields.dst_ip[15:8];
            6'd33: o_byte = i_fields.dst_ip[7:0];
            6'd34: o_byte = i_fields.sport[15:8];
            6'd35: o_byte = i_fields.sport[7:0];
            6'd36: o_byte = i_fields.dport[15:8];
            6'd37: o_byte = i_fields.dport[7:0];
            6'd38: o_byte = i_fields.udp_len[15:8];
            6'd39: o_byte = i_fields.udp_len[7:0];
            // tos, flags/fragment and udp checksum are zero
            default: o_byte = 8'h00;
        endcase
    end

endmodule

FILE: src/udp_ipv4_frame_builder.sv
// udp/ipv4 frame builder top: control sequencer, config registers and output register
// start item: accept, then checksum work, then 42 header bytes
//   one per cycle, then zero padding up to MIN_FRAME bytes when the payload length is zero
// payload item: accept, then one byte out, plus padding after a short frame's end; dropped if no packet is open
// rejected start: one reject byte; output backpressure stretches every byte
// synchronous active-low reset clears control state and loads the register reset values
module udp_ipv4_frame_builder
    import uifb_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
    parameter int MIN_FRAME   = MIN_FRAME_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    uifb_in_if.sink    i_in,
    uifb_out_if.source o_out,
    uifb_cfg_if.sink   i_cfg
);

    t_state r_state, n_state;

    logic [47:0]      r_src_mac;
    logic [31:0]      r_src_ip;
    logic             r_link;

    logic [31:0]      r_dst_ip;
    logic [15:0]      r_sport, r_dport, r_ip_len, r_udp_len, r_ident, r_csum;
    logic             r_plen0;
    logic [LEN_W-1:0] r_exp, r_cnt, r_flen;
    logic             r_open;
    logic [IDX_W-1:0] r_idx;
    logic [7:0]       r_pbyte;

    logic             r_ovalid, r_olast, r_ostat;
    logic [7:0]       r_obyte;

    logic             w_slot, w_in_acc, w_rej, w_emit, w_last, w_stat;
    logic [7:0]       w_byte, w_hbyte;
    logic             w_hdr_end, w_pay_end, w_pay_long, w_pad_last;
    logic [LEN_W-1:0] w_cnt_n, w_pay_len, w_flen_n;
    t_csum_in         w_cin;
    t_csum_out        w_cout;
    t_hdr_fields      w_hf;

    assign w_slot   = !r_ovalid || o_out.ready;
    assign w_in_acc = i_in.valid && i_in.ready;
    assign w_rej    = !r_link || (i_in.payload_length > 16'(MAX_PAYLOAD));

    assign w_hdr_end  = (r_idx == IDX_W'(HDR_LEN - 1));
    assign w_cnt_n    = r_cnt + LEN_W'(1);
    assign w_pay_end  = (w_cnt_n == r_exp);
    assign w_pay_len  = LEN_W'(HDR_LEN) + w_cnt_n;
    assign w_pay_long = (w_pay_len >= LEN_W'(MIN_FRAME));
    assign w_flen_n   = r_flen + LEN_W'(1);
    assign w_pad_last = (w_flen_n == LEN_W'(MIN_FRAME));

    assign w_cin = '{ip_len: r_ip_len, ident: r_ident, src_ip: r_src_ip, dst_ip: r_dst_ip};

    assign w_hf = '{src_mac: r_src_mac, src_ip: r_src_ip, dst_ip: r_dst_ip,
                    sport: r_sport, dport: r_dport, ip_len: r_ip_len,
                    ident: r_ident, udp_len: r_udp_len, csum: r_csum};

    uifb_csum u_csum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_in_acc && (i_in.func == FUNC_START_C) && !w_rej),
        .i_words (w_cin),
        .o_res   (w_cout)
    );

    uifb_hdr u_hdr (
        .i_fields (w_hf),
        .i_idx    (r_idx),
        .o_byte   (w_hbyte)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_in.func == FUNC_START_C) begin
                        n_state = w_rej ? S_REJ : S_CSUM;
                    end else if (r_open) begin
                        n_state = S_PAY;
                    end
                end
            end
            S_CSUM: begin
                if (w_cout.done) begin
                    n_state = S_HDR;
                end
            end
            S_HDR: begin
                if (w_slot && w_hdr_end) begin
                    n_state = (r_plen0 && (HDR_LEN < MIN_FRAME)) ? S_PAD : S_IDLE;
                end
            end
            S_PAY: begin
                if (w_slot) begin
                    n_state = (w_pay_end && !w_pay_long) ? S_PAD : S_IDLE;
                end
            end
            S_PAD: begin
                if (w_slot && w_pad_last) begin
                    n_state = S_IDLE;
                end
            end
            S_REJ: begin
                if (w_slot) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        i_in.ready = 1'b0;
        w_emit     = 1'b0;
        w_byte     = 8'h00;
        w_last     = 1'b0;
        w_stat     = 1'b0;
        case (r_state)
            S_IDLE: i_in.ready = 1'b1;
            S_HDR: begin
                w_emit = w_slot;
                w_byte = w_hbyte;
                w_last = r_plen0 && w_hdr_end && (HDR_LEN >= MIN_FRAME);
            end
            S_PAY: begin
                w_emit = w_slot;
                w_byte = r_pbyte;
                w_last = w_pay_end && w_pay_long;
            end
            S_PAD: begin
                w_emit = w_slot;
                w_last = w_pad_last;
            end
            S_REJ: begin
                w_emit = w_slot;
                w_last = 1'b1;
                w_stat = 1'b1;
            end
            default: w_emit = 1'b0;
        endcase
    end

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_src_mac <= '0;
            r_src_ip  <= SRC_IP_RESET;
            r_link    <= 1'b0;
            r_open    <= 1'b0;
            r_exp     <= '0;
            r_cnt     <= '0;
            r_idx     <= '0;
            r_flen    <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_SOURCE_MAC: r_src_mac <= i_cfg.data;
                    CFG_SOURCE_IP:  r_src_ip  <= i_cfg.data[31:0];
                    CFG_LINK_READY: r_link    <= i_cfg.data[0];
                    default:        r_link    <= r_link;
                endcase
            end

            if (w_in_acc && (i_in.func == FUNC_START_C)) begin
                r_open <= 1'b0;
                r_exp  <= i_in.payload_length[LEN_W-1:0];
                r_cnt  <= '0;
                r_idx  <= '0;
            end

            if (w_emit) begin
                case (r_state)
                    S_HDR: begin
                        r_idx  <= r_idx + IDX_W'(1);
                        r_flen <= LEN_W'(HDR_LEN);
                        if (w_hdr_end && !r_plen0) begin
                            r_open <= 1'b1;
                        end
                    end
                    S_PAY: begin
                        r_cnt  <= w_cnt_n;
                        r_flen <= w_pay_len;
                        if (w_pay_end) begin
                            r_open <= 1'b0;
                        end
                    end
                    S_PAD:   r_flen <= w_flen_n;
                    default: r_flen <= r_flen;
                endcase
            end

            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end

        // item, checksum and output data registers, not reset
        if (w_in_acc) begin
            r_pbyte <= i_in.data_byte;
            if (i_in.func == FUNC_START_C) begin
                r_dst_ip  <= i_in.dest_ip;
                r_sport   <= i_in.sport;
                r_dport   <= i_in.dport;
                r_ident   <= i_in.ip_ident;
                r_ip_len  <= 16'(IP_UDP_HDR) + i_in.payload_length;
                r_udp_len <= 16'(UDP_HDR) + i_in.payload_length;
                r_plen0   <= (i_in.payload_length == 16'h0000);
            end
        end
        if (r_state == S_CSUM && w_cout.done) begin
            r_csum <= w_cout.csum;
        end
        if (w_emit) begin
            r_obyte <= w_byte;
            r_olast <= w_last;
            r_ostat <= w_stat;
        end
    end

    assign o_out.valid      = r_ovalid;
    assign o_out.frame_byte = r_obyte;
    assign o_out.last       = r_olast;
    assign o_out.status     = r_ostat;

    // a reject byte always closes its item
    a_rej_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status) |-> (o_out.last && o_out.frame_byte == 8'h00))
        else $error("reject byte without last");

    // the checksum phase only ends into the header phase
    a_csum_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CSUM) |=> (r_state == S_CSUM || r_state == S_HDR))
        else $error("checksum phase left without header");

    // an open packet always waits for at least one more byte
    a_open_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open |-> (r_cnt < r_exp))
        else $error("open packet with no payload left");

    // padding stays below the minimum frame size
    a_pad_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PAD) |-> (r_flen < LEN_W'(MIN_FRAME)))
        else $error("padding past minimum frame");

endmodule

FILE: tb/sv/tb.sv
// self-checking testbench of the udp/ipv4 frame builder: predicted frame bytes vs observed
module tb;
    import uifb_pkg::*;

    typedef struct {
        logic        func;
        logic [31:0] dest_ip;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [15:0] payload_length;
        logic [15:0] ip_ident;
        logic [7:0]  data_byte;
    } t_in_item;

    typedef struct {
        logic [7:0] frame_byte;
        logic       last;
        logic       status;
    } t_frame_byte;

    class frame_scoreboard;
        logic [47:0] mac_q;
        logic [31:0] ip_q;
        logic        link_q;
        logic [10:0] want_len;
        logic [10:0] got_len;
        logic        pkt_open;
        t_frame_byte frame_q[$];
        int          errors;
        int          n_items;
        int          n_frames;
        int          n_rejects;
        int          n_bytes;

        function new();
            mac_q    = '0;
            ip_q     = SRC_IP_RESET;
            link_q   = 1'b0;
            want_len = '0;
            got_len  = '0;
            pkt_open = 1'b0;
            errors   = 0;
            n_items  = 0;
            n_frames = 0;
            n_rejects = 0;
            n_bytes  = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [47:0] val);
            case (idx)
                CFG_SOURCE_MAC: mac_q  = val;
                CFG_SOURCE_IP:  ip_q   = val[31:0];
                CFG_LINK_READY: link_q = val[0];
                default: ;
            endcase
        endfunction

        function void push(logic [7:0] b, logic l, logic s);
            t_frame_byte e;
            e.frame_byte = b;
            e.last       = l;
            e.status     = s;
            frame_q.push_back(e);
        endfunction

        // zero fill from a frame of len bytes up to the minimum frame size
        function void pad_from(int len);
            int k;
            for (k = len + 1; k <= MIN_FRAME_DEF; k++) begin
                push(8'h00, k == MIN_FRAME_DEF, 1'b0);
            end
        endfunction

        function logic [15:0] ip_csum(logic [15:0] ip_len, logic [15:0] ident,
                                      logic [31:0] dst);
            logic [31:0] acc;
            acc = {IP_VER_IHL, 8'h00} + ip_len + ident + {IP_TTL, IP_PROTO_UDP}
                + ip_q[31:16] + ip_q[15:0] + dst[31:16] + dst[15:0];
            while (acc[31:16] != 0) begin
                acc = acc[15:0] + acc[31:16];
            end
            return ~acc[15:0];
        endfunction

        function void note_item(t_in_item it);
            logic [7:0]  hdr[HDR_LEN];
            logic [15:0] ip_len;
            logic [15:0] udp_len;
            logic [15:0] csum;
            int          i;
            n_items++;
            if (it.func == FUNC_START_C) begin
                pkt_open = 1'b0;
                if (!link_q || it.payload_length > MAX_PAYLOAD_DEF) begin
                    push(8'h00, 1'b1, 1'b1);
                    return;
                end
                ip_len  = 16'(IP_UDP_HDR) + it.payload_length;
                udp_len = 16'(UDP_HDR) + it.payload_length;
                csum    = ip_csum(ip_len, it.ip_ident, it.dest_ip);
                for (i = 0; i < 6; i++) begin
                    hdr[i]     = BCAST_BYTE;
                    hdr[6 + i] = mac_q[47 - 8 * i -: 8];
                end
                hdr[12] = ETHERTYPE_IPV4[15:8];
                hdr[13] = ETHERTYPE_IPV4[7:0];
                hdr[14] = IP_VER_IHL;
                hdr[15] = 8'h00;
                hdr[16] = ip_len[15:8];
                hdr[17] = ip_len[7:0];
                hdr[18] = it.ip_ident[15:8];
                hdr[19] = it.ip_ident[7:0];
                hdr[20] = 8'h00;
                hdr[21] = 8'h00;
                hdr[22] = IP_TTL;
                hdr[23] = IP_PROTO_UDP;
                hdr[24] = csum[15:8];
                hdr[25] = csum[7:0];
                for (i = 0; i < 4; i++) begin
                    hdr[26 + i] = ip_q[31 - 8 * i -: 8];
                    hdr[30 + i] = it.dest_ip[31 - 8 * i -: 8];
                end
                hdr[34] = it.sport[15:8];
                hdr[35] = it.sport[7:0];
                hdr[36] = it.dport[15:8];
                hdr[37] = it.dport[7:0];
                hdr[38] = udp_len[15:8];
                hdr[39] = udp_len[7:0];
                hdr[40] = 8'h00;
                hdr[41] = 8'h00;
                for (i = 0; i < HDR_LEN; i++) begin
                    push(hdr[i], it.payload_length == 0 && i == HDR_LEN - 1
                         && HDR_LEN >= MIN_FRAME_DEF, 1'b0);
                end
                if (it.payload_length == 0) begin
                    pad_from(HDR_LEN);
                end else begin
                    want_len = it.payload_length[10:0];
                    got_len  = '0;
                    pkt_open = 1'b1;
                end
                return;
            end
            // payload byte with no open packet is dropped
            if (!pkt_open) return;
            got_len = got_len + 11'd1;
            if (got_len == want_len) begin
                pkt_open = 1'b0;
                push(it.data_byte, HDR_LEN + got_len >= MIN_FRAME_DEF, 1'b0);
                pad_from(HDR_LEN + got_len);
            end else begin
                push(it.data_byte, 1'b0, 1'b0);
            end
        endfunction

        function void check_byte(logic [7:0] b, logic l, logic s);
            t_frame_byte e;
            if (frame_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("tb: unexpected byte %02h last %b status %b", b, l, s);
                return;
            end
            e = frame_q.pop_front();
            n_bytes++;
            if (l === 1'b1 && s === 1'b1) n_rejects++;
            else if (l === 1'b1) n_frames++;
            if (b !== e.frame_byte || l !== e.last || s !== e.status) begin
                errors++;
                if (errors <= 10)
                    $display("tb: mismatch byte %02h/%02h last %b/%b status %b/%b (exp/got)",
                             e.frame_byte, b, e.last, l, e.status, s);
            end
        endfunction

        function int pending();
            return frame_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   in_burst;
    bit   out_burst;

    uifb_in_if  in_ch();
    uifb_out_if out_ch();
    uifb_cfg_if cfg_ch();

    frame_scoreboard sb = new();

    udp_ipv4_frame_builder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_in_item make_start(logic [31:0] dip, logic [15:0] sp,
                                            logic [15:0] dp, logic [15:0] plen,
                                            logic [15:0] id);
        t_in_item it;
        it.func           = FUNC_START_C;
        it.dest_ip        = dip;
        it.sport          = sp;
        it.dport          = dp;
        it.payload_length = plen;
        it.ip_ident       = id;
        it.data_byte      = 8'($urandom);
        return it;
    endfunction

    function automatic t_in_item make_payload(logic [7:0] b);
        t_in_item it;
        it.func           = FUNC_PAYLOAD_C;
        it.dest_ip        = $urandom;
        it.sport          = 16'($urandom);
        it.dport          = 16'($urandom);
        it.payload_length = 16'($urandom);
        it.ip_ident       = 16'($urandom);
        it.data_byte      = b;
        return it;
    endfunction

    function automatic t_in_item rand_start(logic [15:0] plen);
        return make_start($urandom, 16'($urandom), 16'($urandom), plen, 16'($urandom));
    endfunction

    function automatic logic [15:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 16'($urandom_range(0, 6));
        if (r < 60) return 16'($urandom_range(7, 17));
        // 18 payload bytes make exactly a minimum frame
        if (r < 75) return 16'($urandom_range(18, 19));
        if (r < 95) return 16'($urandom_range(20, 40));
        return 16'($urandom_range(41, 120));
    endfunction

    task automatic send_item(t_in_item it);
        int gap;
        if ($urandom_range(0, 29) == 0) in_burst = !in_burst;
        gap = in_burst ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.func           <= it.func;
        in_ch.dest_ip        <= it.dest_ip;
        in_ch.sport          <= it.sport;
        in_ch.dport          <= it.dport;
        in_ch.payload_length <= it.payload_length;
        in_ch.ip_ident       <= it.ip_ident;
        in_ch.data_byte      <= it.data_byte;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_item(it);
    endtask

    task automatic put_reg(t_cfg_idx idx, logic [47:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.set_reg(idx, val);
    endtask

    task automatic program_regs(logic [47:0] mac, logic [31:0] ip, logic link);
        put_reg(CFG_SOURCE_MAC, mac);
        put_reg(CFG_SOURCE_IP, {16'h0000, ip});
        put_reg(CFG_LINK_READY, {47'h0, link});
        cfg_ch.valid <= 1'b0;
    endtask

    // drain all expected bytes, then allow for trailing work on dropped items
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic run_traffic(int target);
        int          base;
        int          cut;
        int          k;
        logic [15:0] plen;
        base = sb.n_items;
        while (sb.n_items - base < target) begin
            case ($urandom_range(0, 19))
                0: send_item(make_payload(8'($urandom)));
                1: send_item(rand_start(16'($urandom_range(MAX_PAYLOAD_DEF + 1, 65535))));
                2: send_item(rand_start(16'($urandom)));
                default: begin
                    plen = pick_len();
                    send_item(rand_start(plen));
                    // some packets are cut short and abandoned by the next start
                    cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, plen) : plen;
                    for (k = 0; k < cut; k++) send_item(make_payload(8'($urandom)));
                end
            endcase
        end
        while (sb.pkt_open) send_item(make_payload(8'($urandom)));
    endtask

    initial begin
        i_rst_n              <= 1'b0;
        in_ch.valid          <= 1'b0;
        in_ch.func           <= FUNC_START_C;
        in_ch.dest_ip        <= '0;
        in_ch.sport          <= '0;
        in_ch.dport          <= '0;
        in_ch.payload_length <= '0;
        in_ch.ip_ident       <= '0;
        in_ch.data_byte      <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.index         <= CFG_SOURCE_MAC;
        cfg_ch.data          <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // link down after reset: start rejected, its payload dropped
        send_item(rand_start(16'd4));
        send_item(make_payload(8'hA5));
        settle();

        program_regs(48'hFFFF_FFFF_FFFF, 32'h0000_0000, 1'b1);
        send_item(make_start(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF));
        send_item(make_start(32'h0, 16'h0, 16'h0, 16'd0, 16'h0));
        send_item(rand_start(16'(MAX_PAYLOAD_DEF + 1)));
        send_item(rand_start(16'hFFFF));
        send_item(make_payload(8'h5A));
        // abandoned packet, then a one-byte packet padded out
        send_item(rand_start(16'd2));
        send_item(make_payload(8'hFF));
        send_item(rand_start(16'd1));
        send_item(make_payload(8'h00));
        // reject closes an open packet
        send_item(rand_start(16'd3));
        send_item(make_payload(8'h81));
        send_item(rand_start(16'd2000));
        send_item(make_payload(8'h7E));
        // largest accepted length, abandoned after a few bytes
        send_item(rand_start(16'(MAX_PAYLOAD_DEF)));
        send_item(make_payload(8'h3C));
        send_item(make_payload(8'hC3));
        send_item(rand_start(16'd0));
        settle();

        program_regs(48'({$urandom, $urandom}), $urandom, 1'b1);
        run_traffic(90);
        settle();
        program_regs(48'h0, 32'hFFFF_FFFF, 1'b1);
        run_traffic(80);
        settle();
        program_regs(48'({$urandom, $urandom}), $urandom, 1'b0);
        run_traffic(30);
        settle();
        program_regs(48'({$urandom, $urandom}), SRC_IP_RESET, 1'b1);
        run_traffic(110);
        settle();

        $display("tb: %0d items sent, %0d frames and %0d rejections, %0d bytes checked",
                 sb.n_items, sb.n_frames, sb.n_rejects, sb.n_bytes);
        $display("tb: four register settings incl. link down and all-zero/all-one addresses");
        if (sb.errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: %0d mismatches", sb.errors);
            $display("tb: errors");
        end
        $finish;
    end

    // output side stalls at random, with stretches of steady acceptance
    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
            stall = out_burst ? 0 : $urandom_range(0, 5);
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_byte(out_ch.frame_byte, out_ch.last, out_ch.status);
    end

    initial begin
        #8_000_000;
        $display("tb: timeout");
        $display("tb: errors");
        $finish;
    end

endmodule
